>>> rtl/plucker_ray_polygon_test_macros.svh
// Assertion macros for the ray versus polygon test RTL.
`ifndef PLUCKER_RAY_POLYGON_TEST_MACROS_SVH
`define PLUCKER_RAY_POLYGON_TEST_MACROS_SVH

`define PRPT_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define PRPT_ASSERT(label, prop, msg) `PRPT_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

>>> rtl/prpt_pkg.sv
// Types, constants and operand selection for the ray versus polygon test.
package prpt_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned ProdW = 2 * CoordW;
  localparam int unsigned AccW = ProdW + 3;
  localparam int unsigned CountW = 5;
  localparam int unsigned SlotW = 4;
  localparam int unsigned TermW = 3;
  localparam int unsigned MaxEdgesDefault = 16;

  localparam logic [TermW-1:0] TermFirst = 3'd0;
  localparam logic [TermW-1:0] TermLast = 3'd6;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_TEST = 1'b1
  } func_e;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t d_z;
    coord_t d_y;
    coord_t d_x;
    coord_t n_z;
    coord_t n_y;
    coord_t n_x;
  } line_t;

  localparam int unsigned LineW = $bits(line_t);

  typedef struct packed {
    logic clr;
    logic add;
    logic mul;
  } mac_ctrl_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } mac_status_t;

  // Ray side of the permuted inner product: ray D against edge N, then ray N against edge D.
  function automatic coord_t pick_ray(line_t ray, logic [TermW-1:0] term);
    coord_t v;
    case (term)
      3'd0:    v = ray.d_x;
      3'd1:    v = ray.d_y;
      3'd2:    v = ray.d_z;
      3'd3:    v = ray.n_x;
      3'd4:    v = ray.n_y;
      3'd5:    v = ray.n_z;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic coord_t pick_edge(line_t edge_line, logic [TermW-1:0] term);
    coord_t v;
    case (term)
      3'd0:    v = edge_line.n_x;
      3'd1:    v = edge_line.n_y;
      3'd2:    v = edge_line.n_z;
      3'd3:    v = edge_line.d_x;
      3'd4:    v = edge_line.d_y;
      3'd5:    v = edge_line.d_z;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/plucker_ray_polygon_test.sv
// Top level of the Plucker ray versus convex polygon test.
//
// Input words arrive on in_valid_i / in_ready_o. A load word (func_i low)
// writes one edge line into the table slot given by slot_i in the cycle it
// is accepted and gives no result; slots beyond the table are ignored.
// A test word (func_i high) carries a ray and gives one word on
// out_valid_o / out_ready_i, with hit_o high when the ray lies on one side
// of, or on, every edge in use.
// The user must write the edge count register through cfg_valid_i /
// cfg_ready_o only while the block is idle; the block itself does not
// enforce this. Counts above the table size use the whole table.
// A test works through each edge on the single 32 by 32 multiplier, six
// products and one final add. The block can take the next word in the cycle
// its result word is offered; a load word leaves the block idle.
// The block takes no word while a test runs.
// The result sits in an output register, so a new word is accepted while it
// waits; a finished test holds until that register is free.
// Reset clears the edge count and the handshakes; table contents are
// undefined until loaded.
`include "plucker_ray_polygon_test_macros.svh"

module plucker_ray_polygon_test #(
  parameter int unsigned MaxEdges = prpt_pkg::MaxEdgesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [prpt_pkg::SlotW-1:0]    slot_i,
  input  prpt_pkg::coord_t              moment_x_i,
  input  prpt_pkg::coord_t              moment_y_i,
  input  prpt_pkg::coord_t              moment_z_i,
  input  prpt_pkg::coord_t              dir_x_i,
  input  prpt_pkg::coord_t              dir_y_i,
  input  prpt_pkg::coord_t              dir_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [prpt_pkg::CountW-1:0]   cfg_edge_count_i
);

  import prpt_pkg::*;

  localparam int unsigned AddrW = (MaxEdges > 1) ? $clog2(MaxEdges) : 1;
  localparam int unsigned CntW =
      ($clog2(MaxEdges + 1) > CountW) ? $clog2(MaxEdges + 1) : CountW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DONE
  } state_e;

  state_e            state_q;
  logic [CountW-1:0] edge_count_q;
  logic [CntW-1:0]   cnt_q, cnt_d, idx_q, idx_next;
  logic [TermW-1:0]  term_q;
  logic              pos_q, neg_q;
  logic              out_valid_q, hit_q;
  line_t             ray_q, in_line, edge_line;
  logic              accept, accept_load, accept_test;
  logic              ram_we, ram_re;
  logic [AddrW-1:0]  ram_waddr, ram_raddr;
  mac_ctrl_t         mac_ctrl;
  mac_status_t       mac_status;
  logic              last_edge;
  logic              result_load;

  assign in_ready_o = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign hit_o = hit_q;

  assign accept = in_valid_i && in_ready_o;
  assign accept_load = accept && (func_i == FUNC_LOAD);
  assign accept_test = accept && (func_i == FUNC_TEST);

  assign in_line.n_x = moment_x_i;
  assign in_line.n_y = moment_y_i;
  assign in_line.n_z = moment_z_i;
  assign in_line.d_x = dir_x_i;
  assign in_line.d_y = dir_y_i;
  assign in_line.d_z = dir_z_i;

  assign cnt_d = (CntW'(edge_count_q) > CntW'(MaxEdges)) ? CntW'(MaxEdges)
                                                          : CntW'(edge_count_q);
  assign idx_next = idx_q + CntW'(1);
  assign last_edge = (idx_next == cnt_q);
  assign result_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  assign ram_we = accept_load && (CntW'(slot_i) < CntW'(MaxEdges));
  assign ram_waddr = AddrW'(slot_i);
  assign ram_re = accept_test ||
                  ((state_q == ST_MAC) && (term_q == TermLast) && !last_edge);
  assign ram_raddr = (state_q == ST_IDLE) ? AddrW'(0) : AddrW'(idx_next);

  prpt_ram #(
    .Width(LineW),
    .Depth(MaxEdges)
  ) u_edge_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(in_line),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(edge_line)
  );

  always_comb begin
    mac_ctrl = '0;
    if (state_q == ST_MAC) begin
      mac_ctrl.clr = (term_q == TermFirst);
      mac_ctrl.add = (term_q != TermFirst);
      mac_ctrl.mul = (term_q != TermLast);
    end
  end

  prpt_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .a_i     (pick_ray(ray_q, term_q)),
    .b_i     (pick_edge(edge_line, term_q)),
    .status_o(mac_status)
  );

  always_ff @(posedge clk_i) begin
    if (accept_test) begin
      ray_q <= in_line;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      edge_count_q <= '0;
      cnt_q        <= '0;
      idx_q        <= '0;
      term_q       <= TermFirst;
      pos_q        <= 1'b0;
      neg_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      hit_q        <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        edge_count_q <= cfg_edge_count_i;
      end
      if (result_load) begin
        out_valid_q <= 1'b1;
        hit_q       <= !(pos_q && neg_q);
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept_test) begin
            cnt_q  <= cnt_d;
            idx_q  <= '0;
            term_q <= TermFirst;
            pos_q  <= 1'b0;
            neg_q  <= 1'b0;
            state_q <= (cnt_d == '0) ? ST_DONE : ST_MAC;
          end
        end
        ST_MAC: begin
          if (term_q == TermLast) begin
            pos_q  <= pos_q || (!mac_status.neg && !mac_status.zero);
            neg_q  <= neg_q || mac_status.neg;
            term_q <= TermFirst;
            if (last_edge) begin
              state_q <= ST_DONE;
            end else begin
              idx_q <= idx_next;
            end
          end else begin
            term_q <= term_q + TermW'(1);
          end
        end
        ST_DONE: begin
          if (result_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `PRPT_ASSERT(a_test_blocks_input,
               accept_test |=> !in_ready_o,
               "A test word did not make the block busy.")
  `PRPT_ASSERT(a_result_from_done,
               $rose(out_valid_o) |-> $past(state_q == ST_DONE),
               "A result word appeared without a finished test.")
  `PRPT_ASSERT(a_write_only_idle,
               ram_we |-> (state_q == ST_IDLE),
               "The edge table was written during a test.")
  `PRPT_ASSERT(a_index_in_range,
               (state_q == ST_MAC) |-> (idx_q < cnt_q),
               "The edge index ran past the edges in use.")

endmodule

>>> rtl/prpt_ram.sv
// Generic single write port, single read port RAM with registered read data.
module prpt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/prpt_mac.sv
// Shared signed multiply-accumulate unit with the sign and zero flags of the running sum.
module prpt_mac (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  prpt_pkg::mac_ctrl_t ctrl_i,
  input  prpt_pkg::coord_t    a_i,
  input  prpt_pkg::coord_t    b_i,
  output prpt_pkg::mac_status_t status_o
);

  import prpt_pkg::*;

  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic signed [AccW-1:0]  prod_ext;

  assign prod_ext = {{(AccW - ProdW){prod_q[ProdW-1]}}, prod_q};
  assign acc_d = (ctrl_i.clr ? AccW'(0) : acc_q) + (ctrl_i.add ? prod_ext : AccW'(0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      prod_q <= ProdW'(a_i) * ProdW'(b_i);
    end
  end

  assign status_o.neg = acc_d[AccW-1];
  assign status_o.zero = (acc_d == '0);

endmodule
